// File: rtl/pnorm_pkg.sv
// Package for the signed 32-bit peak normaliser.
// Holds payload structs, widths and the full-scale constant; no dependencies.
package pnorm_pkg;

	localparam int unsigned SAMPLE_W  = 32;
	localparam int unsigned MAG_W     = 32;
	// Quotient never exceeds full scale, so 31 bits are enough
	localparam int unsigned QUOT_W    = 31;
	// mag * FULL_SCALE < 2^62
	localparam int unsigned DIVIDEND_W = MAG_W + QUOT_W - 1;
	localparam int unsigned DIV_STEPS = QUOT_W;
	localparam int unsigned STEP_W    = $clog2(DIV_STEPS + 1);

	localparam logic [SAMPLE_W-1:0] FULL_SCALE = 32'h7FFF_FFFF;

	localparam logic MODE_MEASURE = 1'b0;
	localparam logic MODE_SCALE   = 1'b1;

	typedef struct packed {
		logic                       mode;
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last_item;
	} in_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] scaled_sample;
		logic                       clipped;
	} out_t;

endpackage

// File: rtl/pnorm_div.sv
// Bit-serial restoring divider for the peak normaliser: one quotient bit per cycle.
// Depends on pnorm_pkg for widths.
module pnorm_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [pnorm_pkg::DIVIDEND_W-1:0]    dividend,
	input  logic [pnorm_pkg::MAG_W-1:0]         divisor,
	output logic                                done,
	output logic [pnorm_pkg::QUOT_W-1:0]        quotient
);

	logic [pnorm_pkg::MAG_W-1:0]    rem_q;
	logic [pnorm_pkg::QUOT_W-1:0]   low_q;
	logic [pnorm_pkg::MAG_W-1:0]    dsor_q;
	logic [pnorm_pkg::STEP_W-1:0]   cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [pnorm_pkg::MAG_W:0]      trial;
	logic [pnorm_pkg::MAG_W:0]      diff;
	logic                           fits;

	// Shared subtract/compare: shift next dividend bit into the remainder
	assign trial = {rem_q, low_q[pnorm_pkg::QUOT_W-1]};
	assign diff  = trial - {1'b0, dsor_q};
	assign fits  = (trial >= {1'b0, dsor_q});

	// Upper dividend bits are already below the divisor, so start the remainder there
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= pnorm_pkg::STEP_W'(pnorm_pkg::DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == pnorm_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: remainder and shifting dividend/quotient word
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {1'b0, dividend[pnorm_pkg::DIVIDEND_W-1:pnorm_pkg::QUOT_W]};
			low_q  <= dividend[pnorm_pkg::QUOT_W-1:0];
			dsor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[pnorm_pkg::MAG_W-1:0] : trial[pnorm_pkg::MAG_W-1:0];
			low_q <= {low_q[pnorm_pkg::QUOT_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = low_q;

endmodule

// File: rtl/peak_normalize_signed32.sv
// Two-pass peak normaliser for signed 32-bit samples. A measure item (mode 0)
// returns nothing and leaves the block ready for the next item; it folds the
// sample magnitude into the stored peak, and after an item flagged last_item
// the next measure item starts a fresh peak. A scale item (mode 1) returns
// trunc(sample * 2147483647 / peak), saturating to +/-2147483647 with clipped
// set when the magnitude exceeds the peak, and passing the sample through when
// the peak is zero. A divided scale item keeps req_ready low until its result
// has moved to the output register. S_CALC picks the path and forms the
// dividend, and a registered start pulse loads the divider. The bit-serial
// restoring divider then produces one quotient bit per cycle. S_DIV collects
// the quotient, S_DONE moves it to the output register, and the block goes back
// to S_IDLE to take the next item. Zero-peak and clipped samples skip the divider.
// A scale item waits longer while the previous result is still held in the
// output register. The output register lets the next item be taken while a
// result still waits for the downstream side.
// Depends on pnorm_pkg and pnorm_div.
module peak_normalize_signed32 (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  pnorm_pkg::in_t   req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output pnorm_pkg::out_t  rsp
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CALC,
		S_DIV,
		S_DONE
	} state_t;

	state_t                                 state_q;
	logic [pnorm_pkg::MAG_W-1:0]            peak_q;
	logic                                   pass_closed_q;
	logic [pnorm_pkg::MAG_W-1:0]            mag_q;
	logic                                   neg_q;
	logic [pnorm_pkg::SAMPLE_W-1:0]         raw_q;
	pnorm_pkg::out_t                        res_q;
	pnorm_pkg::out_t                        out_q;
	logic                                   out_valid_q;
	logic                                   div_start_q;
	logic [pnorm_pkg::DIVIDEND_W-1:0]       dividend_q;

	logic [pnorm_pkg::MAG_W-1:0]            in_mag;
	logic [pnorm_pkg::MAG_W-1:0]            peak_base;
	logic [pnorm_pkg::DIVIDEND_W:0]         prod_full;
	logic                                   div_done;
	logic [pnorm_pkg::QUOT_W-1:0]           quot;
	logic [pnorm_pkg::SAMPLE_W-1:0]         quot_ext;
	logic                                   accept;
	logic                                   out_free;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign out_free  = !out_valid_q || rsp_ready;

	// Magnitude; -2^31 maps to 2^31 as an unsigned value
	assign in_mag    = req.sample[pnorm_pkg::SAMPLE_W-1] ?
		(~req.sample + 1'b1) : req.sample;
	assign peak_base = pass_closed_q ? '0 : peak_q;

	// mag * (2^31 - 1) as a shift and one wide subtract
	assign prod_full = {mag_q, {pnorm_pkg::QUOT_W{1'b0}}} -
		{{pnorm_pkg::QUOT_W{1'b0}}, mag_q};

	assign quot_ext = {1'b0, quot};

	pnorm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (dividend_q),
		.divisor  (peak_q),
		.done     (div_done),
		.quotient (quot)
	);

	// Sequencer, peak state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			peak_q        <= '0;
			pass_closed_q <= 1'b1;
			out_valid_q   <= 1'b0;
			div_start_q   <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			if (out_valid_q && rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.mode == pnorm_pkg::MODE_MEASURE) begin
							peak_q        <= (in_mag > peak_base) ? in_mag : peak_base;
							pass_closed_q <= req.last_item;
						end else begin
							state_q <= S_CALC;
						end
					end
				end
				S_CALC: begin
					if (peak_q == '0 || mag_q > peak_q) begin
						state_q <= S_DONE;
					end else begin
						div_start_q <= 1'b1;
						state_q     <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q <= in_mag;
			neg_q <= req.sample[pnorm_pkg::SAMPLE_W-1];
			raw_q <= req.sample;
		end
		if (state_q == S_CALC) begin
			dividend_q <= prod_full[pnorm_pkg::DIVIDEND_W-1:0];
			if (peak_q == '0) begin
				res_q.scaled_sample <= raw_q;
				res_q.clipped       <= 1'b0;
			end else if (mag_q > peak_q) begin
				res_q.scaled_sample <= neg_q ? (~pnorm_pkg::FULL_SCALE + 1'b1) :
					pnorm_pkg::FULL_SCALE;
				res_q.clipped       <= 1'b1;
			end
		end
		if (state_q == S_DIV && div_done) begin
			res_q.scaled_sample <= neg_q ? (~quot_ext + 1'b1) : quot_ext;
			res_q.clipped       <= 1'b0;
		end
		if (state_q == S_DONE && out_free) begin
			out_q <= res_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule
